/* sv/mts_pkg.sv */
// mts_pkg: shared types and constants for the min tracking stack
// opcode, fault and controller state encodings, default stack depth
// no dependencies
package mts_pkg;

    localparam int DEFAULT_STACK_DEPTH = 1024;
    localparam int DATA_W              = 32;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_FULL  = 2'd1,
        FAULT_EMPTY = 2'd2
    } fault_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP_RD
    } state_t;

endpackage

/* sv/min_tracking_stack_top.sv */
// min_tracking_stack_top: stack of signed values reporting top and running minimum
// depends on mts_pkg and mts_ram (value store and shadow minimum store)
//
// Each accepted transfer (push, pop or peek) yields one result holding the top value,
// the minimum of all stored values, the entry count, an empty flag and a fault code.
// The top entry and its shadow minimum are held in registers, so a push, a peek and a
// pop that empties the stack need no memory read. A pop that leaves entries behind
// fetches the new top from the two entry memories, whose read data arrives in the
// cycle after the address. A result waits in an output register; the next transfer
// can be taken in the cycle the result is taken, not during a pop refill. A push on a
// full stack and a pop on an empty one leave the stack unchanged and report a fault.
// The memories need no clearing after reset; only entries below the count are ever read.
module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic signed [mts_pkg::DATA_W-1:0] s_push_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [mts_pkg::DATA_W-1:0] m_top_value,
    output logic signed [mts_pkg::DATA_W-1:0] m_min_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0]  m_entry_count,
    output logic                              m_is_empty,
    output logic [1:0]                        m_fault
);
    import mts_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] top_val_reg, top_val_next;
    logic signed [DATA_W-1:0] top_min_reg, top_min_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_top_reg, out_top_next;
    logic signed [DATA_W-1:0] out_min_reg, out_min_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;
    fault_t                   out_fault_reg, out_fault_next;

    logic                     in_xfer;
    logic signed [DATA_W-1:0] push_min;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_val;
    logic [DATA_W-1:0]        rd_min;

    // push and pop never share a cycle, so write and read never hit the same entry
    mts_ram #(.DEPTH(STACK_DEPTH)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_val)
    );

    mts_ram #(.DEPTH(STACK_DEPTH)) u_min_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_min),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_min)
    );

    assign s_ready       = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign in_xfer       = s_valid && s_ready;
    assign m_valid       = out_valid_reg;
    assign m_top_value   = out_top_reg;
    assign m_min_value   = out_min_reg;
    assign m_entry_count = out_count_reg;
    assign m_is_empty    = (out_count_reg == '0);
    assign m_fault       = out_fault_reg;

    assign push_min = ((count_reg == '0) || (s_push_value <= top_min_reg))
                      ? s_push_value : top_min_reg;
    assign wr_addr  = count_reg[ADDR_W-1:0];
    assign rd_addr  = ADDR_W'(count_reg - CNT_W'(2));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_val_next   = top_val_reg;
        top_min_next   = top_min_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_top_next   = out_top_reg;
        out_min_next   = out_min_reg;
        out_count_next = out_count_reg;
        out_fault_next = out_fault_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    out_valid_next = 1'b1;
                    out_fault_next = FAULT_NONE;
                    out_count_next = count_reg;
                    out_top_next   = (count_reg == '0) ? '0 : top_val_reg;
                    out_min_next   = (count_reg == '0) ? '0 : top_min_reg;
                    case (s_opcode)
                        OP_PUSH: begin
                            if (count_reg == CNT_W'(STACK_DEPTH)) begin
                                out_fault_next = FAULT_FULL;
                            end else begin
                                wr_en          = 1'b1;
                                count_next     = count_reg + CNT_W'(1);
                                top_val_next   = s_push_value;
                                top_min_next   = push_min;
                                out_count_next = count_reg + CNT_W'(1);
                                out_top_next   = s_push_value;
                                out_min_next   = push_min;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                out_fault_next = FAULT_EMPTY;
                            end else if (count_reg == CNT_W'(1)) begin
                                count_next     = '0;
                                out_count_next = '0;
                                out_top_next   = '0;
                                out_min_next   = '0;
                            end else begin
                                // refill the top registers from memory
                                rd_en          = 1'b1;
                                count_next     = count_reg - CNT_W'(1);
                                out_valid_next = 1'b0;
                                state_next     = ST_POP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP_RD: begin
                top_val_next   = rd_val;
                top_min_next   = rd_min;
                out_valid_next = 1'b1;
                out_top_next   = rd_val;
                out_min_next   = rd_min;
                out_count_next = count_reg;
                out_fault_next = FAULT_NONE;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_val_reg   <= top_val_next;
        top_min_reg   <= top_min_next;
        out_top_reg   <= out_top_next;
        out_min_reg   <= out_min_next;
        out_count_reg <= out_count_next;
        out_fault_reg <= out_fault_next;
    end

endmodule

/* sv/mts_ram.sv */
// mts_ram: simple dual port synchronous ram, one write and one read port
// read data registered; depends on mts_pkg for data width
module mts_ram #(
    parameter int DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [mts_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [mts_pkg::DATA_W-1:0] rd_data
);
    import mts_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for min_tracking_stack_top
// drives pushes, pops and peeks over valid/ready, checks results against typed rows or a stack model
// depends on mts_pkg and the min_tracking_stack_top rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 250;
    localparam int DIR_N       = 25;

    localparam logic [1:0]         OP_UNUSED = 2'd3;
    localparam logic signed [31:0] VAL_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] top;
        logic signed [31:0] minimum;
        logic [CNT_W-1:0]   count;
        logic               empty;
        fault_t             fault;
    } stack_status_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
        logic               typed;
        stack_status_t      status;
    } stim_row_t;

    localparam stack_status_t NOT_TYPED = '0;

    // typed rows hold the status read straight off the spec, the rest go through the model
    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        '{OP_PEEK,   32'sd0,  1'b1, '{32'sd0, 32'sd0, 0, 1'b1, FAULT_NONE}},
        '{OP_POP,    32'sd0,  1'b1, '{32'sd0, 32'sd0, 0, 1'b1, FAULT_EMPTY}},
        '{OP_UNUSED, 32'sd0,  1'b1, '{32'sd0, 32'sd0, 0, 1'b1, FAULT_NONE}},
        '{OP_PUSH,   VAL_MAX, 1'b1, '{VAL_MAX, VAL_MAX, 1, 1'b0, FAULT_NONE}},
        '{OP_PUSH,   VAL_MIN, 1'b1, '{VAL_MIN, VAL_MIN, 2, 1'b0, FAULT_NONE}},
        '{OP_PUSH,   VAL_MAX, 1'b1, '{VAL_MAX, VAL_MIN, 3, 1'b0, FAULT_NONE}},
        '{OP_PEEK,   VAL_MIN, 1'b1, '{VAL_MAX, VAL_MIN, 3, 1'b0, FAULT_NONE}},
        '{OP_POP,    32'sd0,  1'b1, '{VAL_MIN, VAL_MIN, 2, 1'b0, FAULT_NONE}},
        '{OP_POP,    32'sd0,  1'b1, '{VAL_MAX, VAL_MAX, 1, 1'b0, FAULT_NONE}},
        '{OP_POP,    32'sd0,  1'b1, '{32'sd0, 32'sd0, 0, 1'b1, FAULT_NONE}},
        '{OP_POP,    -32'sd1, 1'b1, '{32'sd0, 32'sd0, 0, 1'b1, FAULT_EMPTY}},
        '{OP_PUSH,   32'sd5,  1'b0, NOT_TYPED},
        '{OP_PUSH,   32'sd5,  1'b0, NOT_TYPED},
        '{OP_PUSH,   32'sd7,  1'b0, NOT_TYPED},
        '{OP_PUSH,   32'sd5,  1'b0, NOT_TYPED},
        '{OP_PUSH,   -32'sd3, 1'b0, NOT_TYPED},
        '{OP_PUSH,   -32'sd3, 1'b0, NOT_TYPED},
        '{OP_PUSH,   32'sd0,  1'b0, NOT_TYPED},
        '{OP_PUSH,   -32'sd1, 1'b0, NOT_TYPED},
        '{OP_POP,    32'sd0,  1'b0, NOT_TYPED},
        '{OP_POP,    32'sd0,  1'b0, NOT_TYPED},
        '{OP_UNUSED, VAL_MAX, 1'b0, NOT_TYPED},
        '{OP_POP,    32'sd0,  1'b0, NOT_TYPED},
        '{OP_POP,    32'sd0,  1'b0, NOT_TYPED},
        '{OP_PEEK,   32'sd0,  1'b0, NOT_TYPED}
    };

    logic                     aclk;
    logic                     aresetn      = 1'b0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_opcode     = OP_PEEK;
    logic signed [31:0]       s_push_value = '0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic signed [31:0]       m_top_value;
    logic signed [31:0]       m_min_value;
    logic [CNT_W-1:0]         m_entry_count;
    logic                     m_is_empty;
    logic [1:0]               m_fault;

    // model state
    logic signed [31:0] model_vals [STACK_DEPTH];
    logic signed [31:0] model_mins [STACK_DEPTH];
    int                 model_fill = 0;

    stack_status_t pending_status[$];

    int  fail_count      = 0;
    int  transfers_sent  = 0;
    int  results_checked = 0;
    int  full_rejects    = 0;
    int  empty_rejects   = 0;
    int  peak_fill       = 0;
    int  cycle_count     = 0;
    bit  quiet_src       = 1'b0;
    bit  quiet_sink      = 1'b0;
    bit  hold_request    = 1'b0;

    min_tracking_stack_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_top_value  (m_top_value),
        .m_min_value  (m_min_value),
        .m_entry_count(m_entry_count),
        .m_is_empty   (m_is_empty),
        .m_fault      (m_fault)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic stack_status_t apply_stack_op(input logic [1:0] op,
                                                     input logic signed [31:0] val);
        stack_status_t      st;
        logic signed [31:0] new_min;
        st = '0;
        st.fault = FAULT_NONE;
        if (op == OP_PUSH) begin
            if (model_fill >= STACK_DEPTH) begin
                st.fault = FAULT_FULL;
                full_rejects++;
            end else begin
                new_min = val;
                if (model_fill > 0 && model_mins[model_fill-1] < val)
                    new_min = model_mins[model_fill-1];
                model_vals[model_fill] = val;
                model_mins[model_fill] = new_min;
                model_fill++;
            end
        end else if (op == OP_POP) begin
            if (model_fill == 0) begin
                st.fault = FAULT_EMPTY;
                empty_rejects++;
            end else begin
                model_fill--;
            end
        end
        if (model_fill > peak_fill)
            peak_fill = model_fill;
        if (model_fill != 0) begin
            st.top     = model_vals[model_fill-1];
            st.minimum = model_mins[model_fill-1];
        end
        st.count = CNT_W'(model_fill);
        st.empty = (model_fill == 0);
        return st;
    endfunction

    function automatic logic [1:0] pick_opcode(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return OP_PUSH;
        if (roll < push_pct + pop_pct)
            return OP_POP;
        return ($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_PEEK;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return -32'sd1;
                    3: return 32'sd1;
                    default: return 32'sd0;
                endcase
            end
            // narrow range so equal values and ties on the minimum show up often
            1, 2, 3: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic signed [31:0] val,
                             input logic typed, input stack_status_t typed_status);
        int            gap;
        stack_status_t predicted;
        gap = quiet_src ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_push_value <= val;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_stack_op(op, val);
        pending_status.push_back(typed ? typed_status : predicted);
        transfers_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(input int n_items, input int push_pct, input int pop_pct,
                               input bit stop_at_full);
        for (int i = 0; i < n_items; i++) begin
            if (stop_at_full && model_fill == STACK_DEPTH)
                break;
            if (i % 64 == 63)
                quiet_src = ($urandom_range(0, 3) == 0);
            send_item(pick_opcode(push_pct, pop_pct), pick_value(), 1'b0, NOT_TYPED);
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin : source
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        for (int r = 0; r < DIR_N; r++)
            send_item(DIR_ROWS[r].opcode, DIR_ROWS[r].value, DIR_ROWS[r].typed,
                      DIR_ROWS[r].status);
        // shallow walk around empty
        send_random(350, 40, 45, 1'b0);
        wait_for_results();
        // fill to the top, the sink holding off at the start, then push against a full stack
        hold_request = 1'b1;
        quiet_src    = 1'b1;
        send_random(4000, 96, 2, 1'b1);
        send_random(40, 80, 10, 1'b0);
        // pop-heavy walk back down
        send_random(300, 35, 55, 1'b0);
        wait_for_results();
        repeat (10) @(posedge aclk);
        $display("%0d transfers sent, %0d results checked, peak depth %0d of %0d",
                 transfers_sent, results_checked, peak_fill, STACK_DEPTH);
        $display("%0d pushes on full and %0d pops on empty were rejected",
                 full_rejects, empty_rejects);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : sink
        int stall;
        int taken;
        taken = 0;
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end else if (quiet_sink) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 19);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid === 1'b1));
            taken++;
            if (taken % 64 == 0)
                quiet_sink = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        stack_status_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("result transfer with nothing pending");
                fail_count++;
            end else begin
                want = pending_status.pop_front();
                results_checked++;
                if (m_top_value !== want.top) begin
                    $error("top_value: expected %0d, got %0d", want.top, m_top_value);
                    fail_count++;
                end
                if (m_min_value !== want.minimum) begin
                    $error("min_value: expected %0d, got %0d", want.minimum, m_min_value);
                    fail_count++;
                end
                if (m_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_entry_count);
                    fail_count++;
                end
                if (m_is_empty !== want.empty) begin
                    $error("is_empty: expected %0d, got %0d", want.empty, m_is_empty);
                    fail_count++;
                end
                if (m_fault !== want.fault) begin
                    $error("fault: expected %0d, got %0d", want.fault, m_fault);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

/* filelist.f */
sv/mts_pkg.sv
sv/mts_ram.sv
sv/min_tracking_stack_top.sv
verif/tb.sv
